// ----- rtl/idcd_pkg.sv -----
// Shared types, constants and a helper function for the identity number check block.
package idcd_pkg;

   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] ASCII_NINE = 8'd57;
   localparam logic [3:0] ID_LENGTH = 4'd11;
   localparam logic [3:0] COUNT_SAT = 4'd12;
   localparam logic [3:0] TENTH_POS = 4'd9;
   localparam logic [8:0] WEIGHT_EVEN = 9'd7;
   localparam logic [8:0] MOD_BIAS = 9'd40;

   // Failure codes, first failing check wins
   typedef enum logic [2:0] {
      REASON_OK       = 3'd0,
      REASON_LENGTH   = 3'd1,
      REASON_NONDIGIT = 3'd2,
      REASON_LEADZERO = 3'd3,
      REASON_CHECK1   = 3'd4,
      REASON_CHECK2   = 3'd5
   } reason_type;

   // Accumulator contents after the current character has been applied
   typedef struct packed {
      logic [3:0] count;
      logic [5:0] even_sum;
      logic [5:0] odd_sum;
      logic [3:0] tenth;
      logic       nondigit;
      logic       lead_zero;
      logic [3:0] digit;
   } acc_type;

   // Remainder mod 10 of a value below 512, by reciprocal multiply
   function automatic logic [3:0] mod10(input logic [8:0] x);
      logic [16:0] prod;
      logic [5:0]  quot;
      logic [8:0]  quot_x10;
      logic [8:0]  rem;
      prod     = {8'd0, x} * 17'd205;
      quot     = prod[16:11];
      quot_x10 = {3'd0, quot} * 9'd10;
      rem      = x - quot_x10;
      return rem[3:0];
   endfunction

endpackage

// ----- rtl/idcd_accum.sv -----
// Position counter, digit sums and flags that accumulate over one identity number.
module idcd_accum (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      char_code,
   input  logic            last_char,
   output idcd_pkg::acc_type acc
);

   logic [3:0] count_ff, count_in;
   logic [5:0] even_ff, even_in;
   logic [5:0] odd_ff, odd_in;
   logic [3:0] tenth_ff, tenth_in;
   logic       nondigit_ff, nondigit_in;
   logic       lead_ff, lead_in;
   logic       is_digit;
   logic [7:0] digit_wide;
   logic [3:0] digit;

   // Decode the character
   assign is_digit   = (char_code >= idcd_pkg::ASCII_ZERO) && (char_code <= idcd_pkg::ASCII_NINE);
   assign digit_wide = char_code - idcd_pkg::ASCII_ZERO;
   assign digit      = is_digit ? digit_wide[3:0] : 4'd0;

   // Apply the character to the running state
   always_comb begin
      count_in    = count_ff;
      even_in     = even_ff;
      odd_in      = odd_ff;
      tenth_in    = tenth_ff;
      nondigit_in = nondigit_ff;
      lead_in     = lead_ff;
      if (count_ff < idcd_pkg::ID_LENGTH) begin
         if (!is_digit) begin
            nondigit_in = 1'b1;
         end else if (count_ff == idcd_pkg::TENTH_POS) begin
            tenth_in = digit;
         end else if (count_ff < idcd_pkg::TENTH_POS) begin
            if (!count_ff[0]) begin
               even_in = even_ff + {2'd0, digit};
            end else begin
               odd_in = odd_ff + {2'd0, digit};
            end
         end
         if ((count_ff == 4'd0) && is_digit && (digit == 4'd0)) begin
            lead_in = 1'b1;
         end
      end
      if (count_ff < idcd_pkg::COUNT_SAT) begin
         count_in = count_ff + 4'd1;
      end
   end

   assign acc = '{count: count_in, even_sum: even_in, odd_sum: odd_in, tenth: tenth_in,
                  nondigit: nondigit_in, lead_zero: lead_in, digit: digit};

   // Advance on each word, clear after the final character
   always_ff @(posedge clock) begin
      if (reset || (step && last_char)) begin
         count_ff    <= '0;
         even_ff     <= '0;
         odd_ff      <= '0;
         tenth_ff    <= '0;
         nondigit_ff <= 1'b0;
         lead_ff     <= 1'b0;
      end else if (step) begin
         count_ff    <= count_in;
         even_ff     <= even_in;
         odd_ff      <= odd_in;
         tenth_ff    <= tenth_in;
         nondigit_ff <= nondigit_in;
         lead_ff     <= lead_in;
      end
   end

endmodule

// ----- rtl/idcd_check.sv -----
// Final checks on the accumulated number: length, digits, leading zero, two check digits.
module idcd_check (
   input  idcd_pkg::acc_type    acc,
   output logic                 is_valid,
   output idcd_pkg::reason_type reason
);

   logic [8:0] chk1_sum;
   logic [8:0] chk2_sum;
   logic [3:0] chk1;
   logic [3:0] chk2;

   // Weighted check: (7*even - odd) mod 10, biased to stay nonnegative
   assign chk1_sum = {3'd0, acc.even_sum} * idcd_pkg::WEIGHT_EVEN + idcd_pkg::MOD_BIAS
                     - {3'd0, acc.odd_sum};
   assign chk2_sum = {3'd0, acc.even_sum} + {3'd0, acc.odd_sum} + {5'd0, acc.tenth};
   assign chk1     = idcd_pkg::mod10(chk1_sum);
   assign chk2     = idcd_pkg::mod10(chk2_sum);

   // Pick the first failing check
   always_comb begin
      if (acc.count != idcd_pkg::ID_LENGTH) begin
         reason = idcd_pkg::REASON_LENGTH;
      end else if (acc.nondigit) begin
         reason = idcd_pkg::REASON_NONDIGIT;
      end else if (acc.lead_zero) begin
         reason = idcd_pkg::REASON_LEADZERO;
      end else if (chk1 != acc.tenth) begin
         reason = idcd_pkg::REASON_CHECK1;
      end else if (chk2 != acc.digit) begin
         reason = idcd_pkg::REASON_CHECK2;
      end else begin
         reason = idcd_pkg::REASON_OK;
      end
   end

   assign is_valid = (reason == idcd_pkg::REASON_OK);

endmodule

// ----- rtl/identity_number_check_digits.sv -----
// Registers in order: input register, then result register holding the result word.
// Throughput: one character per cycle unless a final one stalls; the input register,
//   accumulator update and check logic form one stage feeding the result register.
// A full result register that is not taken stalls only a final character.
// Reset (synchronous, active high) empties both registers and clears all sums and flags.
// Top level of the identity number check block.
module identity_number_check_digits (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // last_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] is_valid, [3:1] fail_reason, [7:4] zero
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_char_ff;
   logic                 s1_last_ff;
   logic                 s1_advance;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_is_valid_ff;
   idcd_pkg::reason_type out_reason_ff;
   idcd_pkg::acc_type    acc;
   logic                 chk_is_valid;
   idcd_pkg::reason_type chk_reason;

   // Stage advances unless a final character meets a full, stalled result register
   assign s1_advance  = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_advance);

   // Hold the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   idcd_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_advance),
      .char_code (s1_char_ff),
      .last_char (s1_last_ff),
      .acc       (acc)
   );

   idcd_check u_check (
      .acc      (acc),
      .is_valid (chk_is_valid),
      .reason   (chk_reason)
   );

   // Result register: load on a final character, drop when taken
   assign out_valid_in = (s1_advance && s1_last_ff) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         out_is_valid_ff <= chk_is_valid;
         out_reason_ff   <= chk_reason;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_reason_ff, out_is_valid_ff};

   // A final character that advances always produces a result word next cycle
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> out_valid_ff)
      else $error("final character did not load a result");

   // The valid flag agrees with the reason code
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_is_valid_ff == (out_reason_ff == idcd_pkg::REASON_OK)))
      else $error("is_valid disagrees with fail_reason");

   // A stalled final character never overwrites a pending result
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !(s1_advance && s1_last_ff))
      else $error("pending result overwritten");

   // The input stage keeps its word while it cannot advance
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_char_ff)))
      else $error("stalled input word lost");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the streamed identity number check block.
module tb_top;

   localparam int IDLE_PCT       = 26;
   localparam int CHAR_TARGET    = 1550;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT    = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {STEP_CHAR, STEP_DRAIN, STEP_RX_HOLD} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [7:0]    code;
      logic          last;
   } char_step_type;

   typedef struct {
      logic                 is_valid;
      idcd_pkg::reason_type reason;
   } verdict_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] char_code
   logic       req_tlast;   // last_char
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [0] is_valid, [3:1] fail_reason, [7:4] zero

   char_step_type pending_chars[$];
   verdict_type   verdicts[$];

   // Predictor copy of the block's accumulators
   logic [3:0] seen_count;
   logic [5:0] even_acc;
   logic [5:0] odd_acc;
   logic [3:0] tenth_held;
   logic       bad_char;
   logic       zero_lead;

   logic       req_taken;
   logic       rx_hold_request;
   int         rx_hold_left;
   int         chars_accepted;
   int         verdicts_seen;
   int         mismatches;
   int         stall_cycles;
   int         chars_queued;
   logic [7:0] num_chars[0:19];

   identity_number_check_digits u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Advance the predictor by one accepted character; emit a verdict on the final one
   task automatic predict_char(input logic [7:0] code, input logic last);
      verdict_type v;
      logic        is_digit;
      logic [3:0]  digit;
      int unsigned chk1;
      int unsigned chk2;
      is_digit = (code >= idcd_pkg::ASCII_ZERO) && (code <= idcd_pkg::ASCII_NINE);
      digit = is_digit ? 4'(code - idcd_pkg::ASCII_ZERO) : 4'd0;
      if (seen_count < idcd_pkg::ID_LENGTH) begin
         if (!is_digit) begin
            bad_char = 1'b1;
         end else if (seen_count == idcd_pkg::TENTH_POS) begin
            tenth_held = digit;
         end else if (seen_count < idcd_pkg::TENTH_POS) begin
            if (!seen_count[0]) begin
               even_acc = even_acc + 6'(digit);
            end else begin
               odd_acc = odd_acc + 6'(digit);
            end
         end
         if (seen_count == 4'd0 && is_digit && digit == 4'd0) begin
            zero_lead = 1'b1;
         end
      end
      if (seen_count < idcd_pkg::COUNT_SAT) begin
         seen_count = seen_count + 4'd1;
      end
      if (last) begin
         // bias by 40 keeps the weighted difference nonnegative (odd sum <= 36)
         chk1 = (7 * int'(even_acc) + 40 - int'(odd_acc)) % 10;
         chk2 = (int'(even_acc) + int'(odd_acc) + int'(tenth_held)) % 10;
         if (seen_count != idcd_pkg::ID_LENGTH) begin
            v.reason = idcd_pkg::REASON_LENGTH;
         end else if (bad_char) begin
            v.reason = idcd_pkg::REASON_NONDIGIT;
         end else if (zero_lead) begin
            v.reason = idcd_pkg::REASON_LEADZERO;
         end else if (chk1 != int'(tenth_held)) begin
            v.reason = idcd_pkg::REASON_CHECK1;
         end else if (chk2 != int'(digit)) begin
            v.reason = idcd_pkg::REASON_CHECK2;
         end else begin
            v.reason = idcd_pkg::REASON_OK;
         end
         v.is_valid = (v.reason == idcd_pkg::REASON_OK);
         verdicts.push_back(v);
         seen_count = 4'd0;
         even_acc   = 6'd0;
         odd_acc    = 6'd0;
         tenth_held = 4'd0;
         bad_char   = 1'b0;
         zero_lead  = 1'b0;
      end
   endtask

   task automatic queue_marker(input step_kind_type kind);
      char_step_type s;
      s.kind = kind;
      s.code = 8'd0;
      s.last = 1'b0;
      pending_chars.push_back(s);
   endtask

   // Queue num_chars[0..len-1], flagging the final character
   task automatic queue_number(input int len);
      char_step_type s;
      for (int i = 0; i < len; i++) begin
         s.kind = STEP_CHAR;
         s.code = num_chars[i];
         s.last = (i == len - 1);
         pending_chars.push_back(s);
      end
      chars_queued += len;
   endtask

   function automatic logic [7:0] random_nondigit();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c >= idcd_pkg::ASCII_ZERO && c <= idcd_pkg::ASCII_NINE) begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // Build one number: well formed, with one targeted defect, or noise
   task automatic queue_random_number();
      int unsigned dig[0:10];
      int unsigned e_sum;
      int unsigned o_sum;
      int          pick;
      int          len;
      pick = $urandom_range(0, 99);
      len = 11;
      dig[0] = (pick >= 61 && pick < 67) ? 0 : $urandom_range(1, 9);
      for (int i = 1; i < 9; i++) begin
         dig[i] = $urandom_range(0, 9);
      end
      e_sum = dig[0] + dig[2] + dig[4] + dig[6] + dig[8];
      o_sum = dig[1] + dig[3] + dig[5] + dig[7];
      dig[9] = (7 * e_sum + 40 - o_sum) % 10;
      dig[10] = (e_sum + o_sum + dig[9]) % 10;
      if (pick >= 45 && pick < 53) begin
         dig[9] = (dig[9] + $urandom_range(1, 9)) % 10;
      end else if (pick >= 53 && pick < 61) begin
         dig[10] = (dig[10] + $urandom_range(1, 9)) % 10;
      end
      for (int i = 0; i < 11; i++) begin
         num_chars[i] = idcd_pkg::ASCII_ZERO + 8'(dig[i]);
      end
      if (pick >= 67 && pick < 77) begin
         num_chars[$urandom_range(0, 10)] = random_nondigit();
      end else if (pick >= 77 && pick < 85) begin
         len = $urandom_range(1, 10);
      end else if (pick >= 85 && pick < 92) begin
         len = $urandom_range(12, 20);
         for (int i = 11; i < len; i++) begin
            num_chars[i] = ($urandom_range(0, 1) != 0)
                           ? random_nondigit()
                           : idcd_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
         end
      end else if (pick >= 92) begin
         len = $urandom_range(1, 20);
         for (int i = 0; i < len; i++) begin
            num_chars[i] = 8'($urandom_range(0, 255));
         end
      end
      queue_number(len);
   endtask

   // Sender: hold an offered word until taken, then offer the next or idle
   always @(negedge clock) begin
      logic          next_valid;
      logic [7:0]    next_data;
      logic          next_last;
      logic          quiet;
      char_step_type s;
      if (!reset && !(req_tvalid && !req_taken)) begin
         next_valid = 1'b0;
         next_data  = 8'd0;
         next_last  = 1'b0;
         quiet = (chars_accepted >= 1000) && (chars_accepted < 1300);
         if (pending_chars.size() != 0 && pending_chars[0].kind == STEP_RX_HOLD) begin
            rx_hold_request = 1'b1;
            void'(pending_chars.pop_front());
         end
         if (pending_chars.size() != 0 && pending_chars[0].kind == STEP_DRAIN
             && verdicts.size() == 0) begin
            void'(pending_chars.pop_front());
         end
         if (pending_chars.size() != 0 && pending_chars[0].kind == STEP_CHAR
             && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            s = pending_chars.pop_front();
            next_valid = 1'b1;
            next_data  = s.code;
            next_last  = s.last;
         end
         req_taken = 1'b0;
         req_tvalid <= next_valid;
         req_tdata  <= next_data;
         req_tlast  <= next_last;
      end
   end

   // Receiver: long hold-off on request, always ready for a window of verdicts, otherwise random back-pressure
   always @(negedge clock) begin
      logic ready;
      if (rx_hold_request) begin
         rx_hold_request = 1'b0;
         rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         ready = 1'b0;
      end else if (verdicts_seen >= 90 && verdicts_seen < 120) begin
         ready = 1'b1;
      end else begin
         ready = ($urandom_range(0, 99) >= IDLE_PCT);
      end
      rsp_tready <= ready;
   end

   // Monitor both channels, check results, and watch for a hang
   always @(posedge clock) begin
      verdict_type want;
      logic        progress;
      if (!reset) begin
         progress = 1'b0;
         if (req_tvalid && req_tready) begin
            predict_char(req_tdata, req_tlast);
            req_taken = 1'b1;
            chars_accepted++;
            progress = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            progress = 1'b1;
            verdicts_seen++;
            if (verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("[%0t] result word %h with no verdict pending", $realtime, rsp_tdata);
               end
            end else begin
               want = verdicts.pop_front();
               if (rsp_tdata[0] !== want.is_valid || rsp_tdata[3:1] !== want.reason) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("[%0t] verdict mismatch: expected valid=%0d reason=%0d,",
                              $realtime, want.is_valid, want.reason,
                              " got valid=%0d reason=%0d", rsp_tdata[0], rsp_tdata[3:1]);
                  end
               end
            end
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = 8'd0;
      req_tlast       = 1'b0;
      rsp_tready      = 1'b0;
      req_taken       = 1'b0;
      rx_hold_request = 1'b0;
      rx_hold_left    = 0;
      chars_accepted  = 0;
      verdicts_seen   = 0;
      mismatches      = 0;
      stall_cycles    = 0;
      chars_queued    = 0;
      seen_count      = 4'd0;
      even_acc        = 6'd0;
      odd_acc         = 6'd0;
      tenth_held      = 4'd0;
      bad_char        = 1'b0;
      zero_lead       = 1'b0;

      // Directed: minimal valid number, lone NUL and 0xFF finals, all-nines valid number
      for (int i = 0; i < 11; i++) begin
         num_chars[i] = idcd_pkg::ASCII_ZERO;
      end
      num_chars[0]  = idcd_pkg::ASCII_ZERO + 8'd1;
      num_chars[9]  = idcd_pkg::ASCII_ZERO + 8'd7;
      num_chars[10] = idcd_pkg::ASCII_ZERO + 8'd8;
      queue_number(11);
      num_chars[0] = 8'h00;
      queue_number(1);
      num_chars[0] = 8'hFF;
      queue_number(1);
      for (int i = 0; i < 10; i++) begin
         num_chars[i] = idcd_pkg::ASCII_NINE;
      end
      num_chars[10] = idcd_pkg::ASCII_ZERO;
      queue_number(11);
      queue_marker(STEP_DRAIN);

      // Random numbers, with receiver hold-offs and full drains queued in two windows of the character count
      while (chars_queued < CHAR_TARGET) begin
         if (chars_queued >= 400 && chars_queued < 420) begin
            queue_marker(STEP_RX_HOLD);
         end
         if (chars_queued >= 800 && chars_queued < 820) begin
            queue_marker(STEP_DRAIN);
         end
         queue_random_number();
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every word to be taken and every verdict to arrive
      while (pending_chars.size() != 0 || (req_tvalid && !req_taken)) @(negedge clock);
      while (verdicts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
